>>> sv/pba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants of the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

   localparam int MAX_PAGES      = 32768;
   localparam int PAGE_BYTES     = 256;
   localparam int BITS_PER_PAGE  = 2;

   localparam int WORD_W         = 32;
   localparam int ADDR_W         = 32;
   localparam int REQ_W          = 24;
   localparam int PAGES_REG_W    = 16;
   localparam int CSR_IDX_W      = 4;

   localparam int MARKS_PER_WORD = WORD_W / BITS_PER_PAGE;
   localparam int LANE_W         = $clog2(MARKS_PER_WORD);
   localparam int MAP_WORDS      = (MAX_PAGES + MARKS_PER_WORD - 1) / MARKS_PER_WORD;
   localparam int MAP_AW         = $clog2(MAP_WORDS);
   localparam int PIDX_W         = MAP_AW + LANE_W;
   localparam int CNT_W          = $clog2(MAX_PAGES + 1);
   localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
   localparam int NEED_W         = REQ_W - PAGE_SHIFT + 1;
   localparam int POFF_W         = ADDR_W - PAGE_SHIFT;

   localparam logic [BITS_PER_PAGE-1:0] MARK_USED = 2'b01;
   localparam logic [BITS_PER_PAGE-1:0] MARK_LAST = 2'b10;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_BASE  = 4'd0,
      CSR_REGION_PAGES = 4'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK_PREP,
      ST_MARK,
      ST_PAGE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [ADDR_W-1:0]        address;
      logic [REQ_W-1:0]         request_bytes;
      logic [BITS_PER_PAGE-1:0] new_bits;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]        result_address;
      logic                     ok;
      logic [BITS_PER_PAGE-1:0] page_bits;
   } rsp_type;

   typedef struct packed {
      logic              hit;
      logic [LANE_W-1:0] lane;
      logic [CNT_W-1:0]  carry;
   } scan_result_type;

endpackage

>>> sv/pba_word_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_word_scan
// Checks one map word for the top-down first-fit run, given the free run
// carried in from the words above; returns hit lane and carry to the next word.
// ----------------------------------------------------------------------------
module pba_word_scan import pba_pkg::*; (
   input  logic [WORD_W-1:0]         map_word,
   input  logic [MARKS_PER_WORD-1:0] lane_mask,
   input  logic [CNT_W-1:0]          carry,
   input  logic [CNT_W-1:0]          need,
   output scan_result_type           result
);

   logic [MARKS_PER_WORD-1:0] free;
   logic [MARKS_PER_WORD-1:0] full;
   logic [MARKS_PER_WORD-1:0] win;
   logic [MARKS_PER_WORD-1:0] hit;
   logic [CNT_W-1:0]          trail;

   always_comb begin
      for (int j = 0; j < MARKS_PER_WORD; j++) begin
         free[j] = lane_mask[j] & ~map_word[j*BITS_PER_PAGE];
      end
      for (int j = 0; j < MARKS_PER_WORD; j++) begin
         full[j] = 1'b1;
         win[j]  = 1'b1;
         for (int k = 0; k < MARKS_PER_WORD; k++) begin
            if (k >= j) begin
               full[j] = full[j] & free[k];
               if ((k - j) < int'(need)) begin
                  win[j] = win[j] & free[k];
               end
            end
         end
         if (32'(need) <= 32'(MARKS_PER_WORD - j)) begin
            hit[j] = win[j];
         end else begin
            hit[j] = full[j] && ((32'(carry) + 32'(MARKS_PER_WORD - j)) >= 32'(need));
         end
      end

      result.hit  = |hit;
      result.lane = '0;
      for (int j = 0; j < MARKS_PER_WORD; j++) begin
         if (hit[j]) begin
            result.lane = LANE_W'(j);
         end
      end

      trail = CNT_W'(MARKS_PER_WORD);
      for (int j = MARKS_PER_WORD - 1; j >= 0; j--) begin
         if (!free[j]) begin
            trail = CNT_W'(j);
         end
      end
      result.carry = full[0] ? CNT_W'(32'(carry) + 32'(MARKS_PER_WORD)) : trail;
   end

endmodule

>>> sv/page_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_bitmap_allocator_core
// First-fit page allocator over a 2-bit-per-page map held in a block memory.
// ----------------------------------------------------------------------------
// read/write mark: ST_PAGE, then ST_DONE; rejected commands go to ST_DONE
// allocate: ST_SCAN, ST_MARK_PREP, ST_MARK, ST_DONE, one map word per cycle
// through the single read port of the map memory
// one command at a time; the next is taken while a result waits for transfer
// reset: synchronous; a clearing pass of MAP_WORDS (2048) words zeroes the map,
// commands are held off until it ends, register writes are taken at once
module page_bitmap_allocator_core import pba_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   logic [WORD_W-1:0] map_mem [MAP_WORDS];
   logic [WORD_W-1:0] rd_q_ff;
   logic [MAP_AW-1:0] rd_addr;
   logic              wr_en;
   logic [MAP_AW-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;

   state_type state_ff, state_in;
   logic [MAP_AW-1:0]        clr_ff, clr_in;
   logic [1:0]               cmd_ff, cmd_in;
   logic [BITS_PER_PAGE-1:0] new_bits_ff, new_bits_in;
   logic [PIDX_W-1:0]        page_ff, page_in;
   logic [CNT_W-1:0]         need_ff, need_in;
   logic [MAP_AW-1:0]        top_word_ff, top_word_in;
   logic [LANE_W-1:0]        top_lane_ff, top_lane_in;
   logic [MAP_AW-1:0]        scan_word_ff, scan_word_in;
   logic [CNT_W-1:0]         carry_ff, carry_in;
   logic [PIDX_W-1:0]        lo_ff, lo_in;
   logic [PIDX_W-1:0]        hi_ff, hi_in;
   logic [MAP_AW-1:0]        mark_word_ff, mark_word_in;
   rsp_type                  res_ff, res_in;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;
   logic                     load_rsp;
   logic [ADDR_W-1:0]        base_ff;
   logic [PAGES_REG_W-1:0]   pages_ff;

   logic [CNT_W-1:0]          live;
   logic [REQ_W:0]            need_sum;
   logic [NEED_W-1:0]         need_wide;
   logic                      alloc_ok;
   logic [ADDR_W-1:0]         offset;
   logic [POFF_W-1:0]         page_off;
   logic                      page_ok;
   logic [PIDX_W-1:0]         page_idx;
   logic [PIDX_W-1:0]         last_page;
   logic [MARKS_PER_WORD-1:0] lane_mask;
   scan_result_type           scan;
   logic [WORD_W-1:0]         marked_word;
   logic [WORD_W-1:0]         patched_word;
   logic [PIDX_W-1:0]         q;

   // map memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= map_mem[rd_addr];
   end

   // registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         pages_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REGION_BASE:  base_ff  <= csr_wdata;
            CSR_REGION_PAGES: pages_ff <= csr_wdata[PAGES_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // request decode
   always_comb begin
      if (32'(pages_ff) > 32'(MAX_PAGES)) begin
         live = CNT_W'(MAX_PAGES);
      end else begin
         live = CNT_W'(pages_ff);
      end
      need_sum  = {1'b0, req_data.request_bytes} + (REQ_W+1)'(PAGE_BYTES - 1);
      need_wide = NEED_W'(need_sum >> PAGE_SHIFT);
      alloc_ok  = (need_wide != '0) && (32'(need_wide) <= 32'(live));
      offset    = req_data.address - base_ff;
      page_off  = POFF_W'(offset >> PAGE_SHIFT);
      page_ok   = 32'(page_off) < 32'(live);
      page_idx  = PIDX_W'(page_off);
      last_page = PIDX_W'(32'(live) - 32'd1);
   end

   // scan lanes above the region's last page count as used
   always_comb begin
      for (int j = 0; j < MARKS_PER_WORD; j++) begin
         lane_mask[j] = (scan_word_ff != top_word_ff) || (LANE_W'(j) <= top_lane_ff);
      end
   end

   pba_word_scan u_word_scan (
      .map_word  (rd_q_ff),
      .lane_mask (lane_mask),
      .carry     (carry_ff),
      .need      (need_ff),
      .result    (scan)
   );

   // word updates for marking a run and for a single page write
   always_comb begin
      marked_word  = rd_q_ff;
      patched_word = rd_q_ff;
      q            = '0;
      for (int j = 0; j < MARKS_PER_WORD; j++) begin
         q = {mark_word_ff, LANE_W'(j)};
         if ((q >= lo_ff) && (q <= hi_ff)) begin
            marked_word[j*BITS_PER_PAGE +: BITS_PER_PAGE] =
               (q == hi_ff) ? (MARK_USED | MARK_LAST) : MARK_USED;
         end
         if (LANE_W'(j) == page_ff[LANE_W-1:0]) begin
            patched_word[j*BITS_PER_PAGE +: BITS_PER_PAGE] = new_bits_ff;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      new_bits_ff  <= new_bits_in;
      page_ff      <= page_in;
      need_ff      <= need_in;
      top_word_ff  <= top_word_in;
      top_lane_ff  <= top_lane_in;
      scan_word_ff <= scan_word_in;
      carry_ff     <= carry_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mark_word_ff <= mark_word_in;
      res_ff       <= res_in;
      if (load_rsp) begin
         rsp_data_ff <= res_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      new_bits_in  = new_bits_ff;
      page_in      = page_ff;
      need_in      = need_ff;
      top_word_in  = top_word_ff;
      top_lane_in  = top_lane_ff;
      scan_word_in = scan_word_ff;
      carry_in     = carry_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mark_word_in = mark_word_ff;
      res_in       = res_ff;
      req_stall    = 1'b1;
      load_rsp     = 1'b0;
      rd_addr      = scan_word_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == MAP_AW'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_data.cmd == CMD_ALLOC) begin
               rd_addr = last_page[PIDX_W-1:LANE_W];
            end else begin
               rd_addr = page_idx[PIDX_W-1:LANE_W];
            end
            if (req_valid) begin
               cmd_in       = req_data.cmd;
               new_bits_in  = req_data.new_bits;
               page_in      = page_idx;
               need_in      = CNT_W'(need_wide);
               top_word_in  = last_page[PIDX_W-1:LANE_W];
               top_lane_in  = last_page[LANE_W-1:0];
               scan_word_in = last_page[PIDX_W-1:LANE_W];
               carry_in     = '0;
               res_in       = '0;
               case (req_data.cmd)
                  CMD_ALLOC:            state_in = alloc_ok ? ST_SCAN : ST_DONE;
                  CMD_READ, CMD_WRITE:  state_in = page_ok ? ST_PAGE : ST_DONE;
                  default:              state_in = ST_DONE;
               endcase
            end
         end

         ST_SCAN: begin
            rd_addr = scan_word_ff - 1'b1;
            if (scan.hit) begin
               lo_in    = {scan_word_ff, scan.lane};
               state_in = ST_MARK_PREP;
            end else if (scan_word_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               scan_word_in = scan_word_ff - 1'b1;
               carry_in     = scan.carry;
            end
         end

         ST_MARK_PREP: begin
            hi_in                 = PIDX_W'(32'(lo_ff) + 32'(need_ff) - 32'd1);
            mark_word_in          = lo_ff[PIDX_W-1:LANE_W];
            rd_addr               = lo_ff[PIDX_W-1:LANE_W];
            res_in.result_address = base_ff + (ADDR_W'(lo_ff) << PAGE_SHIFT);
            res_in.ok             = 1'b1;
            state_in              = ST_MARK;
         end

         ST_MARK: begin
            wr_en   = 1'b1;
            wr_addr = mark_word_ff;
            wr_data = marked_word;
            rd_addr = mark_word_ff + 1'b1;
            if (mark_word_ff == hi_ff[PIDX_W-1:LANE_W]) begin
               state_in = ST_DONE;
            end else begin
               mark_word_in = mark_word_ff + 1'b1;
            end
         end

         ST_PAGE: begin
            res_in.ok = 1'b1;
            if (cmd_ff == CMD_READ) begin
               res_in.page_bits = BITS_PER_PAGE'(rd_q_ff >>
                                  (32'(page_ff[LANE_W-1:0]) * BITS_PER_PAGE));
            end else begin
               wr_en   = 1'b1;
               wr_addr = page_ff[PIDX_W-1:LANE_W];
               wr_data = patched_word;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
